[design/swm_pkg.sv]
// Shared types and constants for the sliding-window median filter.
// No dependencies; swm_cell and the top module import this package.
package swm_pkg;

  // Fixed field widths of the block's ports and the window size after reset.
  localparam int IN_W    = 32;
  localparam int OUT_W   = 33;
  localparam int CFG_W   = 7;
  localparam int WS_INIT = 3;

  // Compare flags that each cell of the sorted chain shows its neighbors.
  typedef struct packed {
    logic gt_s;  // entry lies above the new sample (empty entries count as above)
    logic ge_d;  // entry is at or past the value being dropped
  } swm_flags_t;

endpackage

[design/swm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the sample history line.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/swm_cell.sv]
// One sorted-chain entry; per request inserts one value and, with drop_en, drops one.
// Depends on swm_pkg for the neighbor flag struct.
module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int CNT_W       = 7,
  parameter int IDX         = 0
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] new_val,
  input  logic                          drop_en,
  input  logic signed [SAMPLE_BITS-1:0] drop_val,
  input  logic [CNT_W-1:0]              fill,
  input  logic signed [SAMPLE_BITS-1:0] left_val,
  input  swm_flags_t                    left_flg,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  swm_flags_t                    right_flg,
  output logic signed [SAMPLE_BITS-1:0] val,
  output swm_flags_t                    flg
);

  logic                          occupied;
  logic signed [SAMPLE_BITS-1:0] cur_val;
  logic                          cur_gt;
  logic signed [SAMPLE_BITS-1:0] lft_val;
  logic                          lft_gt;
  logic signed [SAMPLE_BITS-1:0] val_next;

  assign occupied = CNT_W'(IDX) < fill;
  assign flg.gt_s = !occupied || (val > new_val);
  assign flg.ge_d = drop_en && (!occupied || (val >= drop_val));

  // After the drop, this slot holds either its own value or the right neighbor's,
  // and the slot to the left holds either the left neighbor's value or this one's.
  assign cur_val = flg.ge_d ? right_val : val;
  assign cur_gt  = flg.ge_d ? right_flg.gt_s : flg.gt_s;
  assign lft_val = left_flg.ge_d ? val : left_val;
  assign lft_gt  = left_flg.ge_d ? flg.gt_s : left_flg.gt_s;

  always_comb begin
    priority if (!cur_gt) begin
      val_next = cur_val;
    end else if (!lft_gt) begin
      val_next = new_val;
    end else begin
      val_next = lft_val;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
    end
  end

endmodule

[design/sliding_window_median_top.sv]
// Sliding-window median filter. Accepts one sample per clock while in_stall is
// low; an accepted sample updates the sorted cells and marks its result pending,
// and that result is loaded into the output register once it is free. A row of
// MAX_WINDOW cells keeps the window sorted and applies drop-oldest plus insert-new
// as one update, and the oldest sample is read from a history RAM whose read
// address is prefetched. The input stalls only while a finished result is
// waiting and the output register is still held. No result is given until a
// stream has filled its window; a write to window_size starts a new stream.
// Depends on swm_pkg, swm_ram and swm_cell.
module sliding_window_median_top import swm_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  sample,
  input  logic                    start_of_stream,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] median_doubled,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        window_size
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1;
  localparam int W_RESET = WS_INIT > MAX_WINDOW ? MAX_WINDOW : WS_INIT;

  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] fill;
  logic [PTR_W-1:0] ptr;
  logic             pend;
  logic             fwd_hit;
  logic signed [SAMPLE_BITS-1:0] fwd_val;

  logic                          in_acc;
  logic                          cfg_acc;
  logic                          pend_load;
  logic signed [SAMPLE_BITS-1:0] s_val;
  logic [CNT_W-1:0]              fill0;
  logic                          drop;
  logic [CNT_W-1:0]              fill_next;
  logic [PTR_W-1:0]              p0;
  logic [CNT_W-1:0]              ptr_inc;
  logic [PTR_W-1:0]              ptr_next;
  logic [PTR_W-1:0]              rd_addr;
  logic signed [SAMPLE_BITS-1:0] hist_rdata;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic [CNT_W-1:0]              w_cfg;
  logic [CNT_W-1:0]              lo_idx;
  logic [CNT_W-1:0]              hi_idx;
  logic signed [SAMPLE_BITS-1:0] lo_val;
  logic signed [SAMPLE_BITS-1:0] hi_val;

  logic signed [SAMPLE_BITS-1:0] vals [MAX_WINDOW];
  swm_flags_t                    flgs [MAX_WINDOW];

  assign in_stall  = pend && out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = !pend;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign pend_load = pend && (!out_valid || !out_stall);

  assign s_val = sample[SAMPLE_BITS-1:0];

  // A start flag empties the window before the sample enters.
  assign fill0     = start_of_stream ? '0 : fill;
  assign p0        = start_of_stream ? '0 : ptr;
  assign drop      = fill0 >= w_eff;
  assign fill_next = drop ? fill0 : fill0 + 1'b1;
  assign ptr_inc   = CNT_W'(p0) + 1'b1;
  assign ptr_next  = (ptr_inc >= w_eff) ? '0 : ptr_inc[PTR_W-1:0];

  // Prefetch the slot that the next sample will replace. With a one-sample window
  // that slot is the one being written now, so the written value is forwarded.
  assign rd_addr = in_acc ? ptr_next : ptr;
  assign oldest  = fwd_hit ? fwd_val : hist_rdata;

  always_comb begin
    priority if (window_size == '0) begin
      w_cfg = CNT_W'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      w_cfg = CNT_W'(MAX_WINDOW);
    end else begin
      w_cfg = CNT_W'(window_size);
    end
  end

  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (in_acc),
    .waddr (p0),
    .wdata (s_val),
    .raddr (rd_addr),
    .rdata (hist_rdata)
  );

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] l_val;
    logic signed [SAMPLE_BITS-1:0] r_val;
    swm_flags_t                    l_flg;
    swm_flags_t                    r_flg;

    if (j == 0) begin : g_first
      assign l_val = '0;
      assign l_flg = '{gt_s: 1'b0, ge_d: 1'b0};
    end else begin : g_mid_l
      assign l_val = vals[j-1];
      assign l_flg = flgs[j-1];
    end

    if (j == MAX_WINDOW - 1) begin : g_last
      assign r_val = '0;
      assign r_flg = '{gt_s: 1'b1, ge_d: 1'b1};
    end else begin : g_mid_r
      assign r_val = vals[j+1];
      assign r_flg = flgs[j+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .IDX         (j)
    ) u_cell (
      .clk       (clk),
      .load      (in_acc),
      .new_val   (s_val),
      .drop_en   (drop),
      .drop_val  (oldest),
      .fill      (fill0),
      .left_val  (l_val),
      .left_flg  (l_flg),
      .right_val (r_val),
      .right_flg (r_flg),
      .val       (vals[j]),
      .flg       (flgs[j])
    );
  end

  // For odd sizes both indexes name the middle entry, so the sum is twice it.
  assign lo_idx = (w_eff - 1'b1) >> 1;
  assign hi_idx = w_eff >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (CNT_W'(i) == lo_idx) begin
        lo_val = vals[i];
      end
      if (CNT_W'(i) == hi_idx) begin
        hi_val = vals[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff     <= CNT_W'(W_RESET);
      fill      <= '0;
      ptr       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      fwd_hit <= in_acc && (ptr_next == p0);
      if (cfg_acc) begin
        w_eff <= w_cfg;
        fill  <= '0;
        ptr   <= '0;
      end else if (in_acc) begin
        fill <= fill_next;
        ptr  <= ptr_next;
      end
      if (in_acc) begin
        pend <= (fill_next == w_eff);
      end else if (pend_load) begin
        pend <= 1'b0;
      end
      if (pend_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_val <= s_val;
    end
    if (pend_load) begin
      median_doubled <= OUT_W'(lo_val) + OUT_W'(hi_val);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= w_eff)
    else $error("fill count exceeds the window size");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(ptr) < w_eff)
    else $error("history pointer outside the window");

  a_fwd_unit: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> (w_eff == CNT_W'(1)))
    else $error("history forwarding used with a window larger than one");

  a_full_emits: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !start_of_stream && (fill == w_eff)) |=> pend)
    else $error("request on a full window produced no result");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_median_top: a directed table, a back-pressure run, then random streams.
// Each accepted sample is run through a sorted-window predictor; results are compared in order.
// Depends on swm_pkg and the sliding_window_median_top RTL.
module tb_top;
  import swm_pkg::*;

  localparam int MAXW        = 64;
  localparam int LAT_PAD     = 4;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 320;

  typedef logic signed [IN_W-1:0]  samp_t;
  typedef logic signed [OUT_W-1:0] med_t;
  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] val;
    bit          sos;
    bit          typed;
    med_t        med;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  samp_t            sample = '0;
  logic             start_of_stream = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  med_t             median_doubled;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] window_size = '0;

  // Predictor state: circular history, sorted copy, fill level and write slot.
  samp_t            win_hist [MAXW];
  samp_t            win_sorted [MAXW];
  int unsigned      win_fill;
  int unsigned      win_ptr;
  logic [CFG_W-1:0] win_size_reg;

  med_t     median_q [$];
  dir_row_t dir_rows [$];
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;
  bit       steady = 1'b0;
  bit       hold_req = 1'b0;

  sliding_window_median_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .start_of_stream (start_of_stream),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .median_doubled  (median_doubled),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .window_size     (window_size)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned win_span();
    if (win_size_reg == 0) return 1;
    if (win_size_reg > MAXW) return MAXW;
    return win_size_reg;
  endfunction

  // Advances the predicted window by one sample; returns 1 when a median is due.
  function automatic bit median_of_window(input samp_t s, input bit sos, output med_t med);
    int unsigned w;
    int unsigned i;
    int unsigned j;
    samp_t       old;
    bit          found;
    w = win_span();
    med = '0;
    if (sos) begin
      win_fill = 0;
      win_ptr = 0;
    end
    if (win_ptr >= w) win_ptr = 0;
    // With a full window, exactly one entry equal to the oldest sample leaves.
    if (win_fill >= w) begin
      old = win_hist[win_ptr];
      found = 1'b0;
      for (i = 0; i < win_fill && !found; i++) begin
        if (win_sorted[i] == old) begin
          for (j = i; j + 1 < win_fill; j++) win_sorted[j] = win_sorted[j + 1];
          found = 1'b1;
        end
      end
      if (found) win_fill--;
    end
    if (win_fill < MAXW) begin
      i = win_fill;
      while (i > 0 && win_sorted[i - 1] > s) begin
        win_sorted[i] = win_sorted[i - 1];
        i--;
      end
      win_sorted[i] = s;
      win_fill++;
    end
    win_hist[win_ptr] = s;
    win_ptr++;
    if (win_ptr >= w) win_ptr = 0;
    if (win_fill < w) return 1'b0;
    if (w % 2 == 1) begin
      med = {win_sorted[w / 2], 1'b0};
    end else begin
      med = {win_sorted[w / 2 - 1][IN_W-1], win_sorted[w / 2 - 1]}
          + {win_sorted[w / 2][IN_W-1], win_sorted[w / 2]};
    end
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic offer_sample(input samp_t s, input bit sos, input bit typed,
                              input med_t typed_med);
    med_t med;
    bit   due;
    if (!steady) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        sample <= $urandom;
        start_of_stream <= $urandom_range(0, 1);
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    sample <= s;
    start_of_stream <= sos;
    do @(posedge clk); while (in_stall);
    due = median_of_window(s, sos, med);
    if (typed) begin
      median_q = {median_q, typed_med};
    end else if (due) begin
      median_q = {median_q, med};
    end
    @(negedge clk);
  endtask

  // Drains the block, then writes window_size. Called and returns at a falling edge.
  task automatic write_window_size(input logic [CFG_W-1:0] size);
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (LAT_PAD) @(negedge clk);
    cfg_valid <= 1'b1;
    window_size <= size;
    do @(posedge clk); while (!cfg_ready);
    win_size_reg = size;
    win_fill = 0;
    win_ptr = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Appends one row to the directed table.
  function automatic void add_row(input row_kind_t kind, input logic [31:0] val,
                                  input bit sos, input bit typed, input med_t med);
    dir_rows = {dir_rows, dir_row_t'{kind, val, sos, typed, med}};
  endfunction

  // Receiver: random stalls, one long counted hold when the stimulus asks for it.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    med_t want;
    if (!rst && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        if (mismatch_cnt < 10) $display("unexpected median result %0d", median_doubled);
        mismatch_cnt++;
      end else begin
        want = median_q.pop_front();
        if (median_doubled !== want) begin
          if (mismatch_cnt < 10)
            $display("median_doubled mismatch: expected %0d, got %0d", want, median_doubled);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sliding_window_median_top verification failed");
      $finish;
    end
  end

  initial begin
    int    rand_items;
    int    n;
    int    r;
    int    k;
    bit    sos;
    samp_t s;
    samp_t last_s;
    logic [CFG_W-1:0] size;

    for (k = 0; k < MAXW; k++) begin
      win_hist[k] = '0;
      win_sorted[k] = '0;
    end
    win_fill = 0;
    win_ptr = 0;
    win_size_reg = CFG_W'(WS_INIT);

    // Reset window of three: extremes, equal values, restarts mid-stream.
    add_row(ROW_SAMPLE, 32'h7fff_ffff, 1'b1, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'h7fff_ffff, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'h7fff_ffff, 1'b0, 1'b1, 33'sh0_ffff_fffe);
    add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'sh0_ffff_fffe);
    add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'sh1_0000_0000);
    add_row(ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'sh1_0000_0000);
    add_row(ROW_SAMPLE, 32'd5, 1'b1, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd5, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd5, 1'b0, 1'b1, 33'sd10);
    add_row(ROW_SAMPLE, 32'hffff_fffd, 1'b0, 1'b1, 33'sd10);
    add_row(ROW_SAMPLE, 32'd0, 1'b0, 1'b1, 33'sd0);
    add_row(ROW_SAMPLE, 32'd0, 1'b1, 1'b0, '0);
    // Even window sums the two middle values.
    add_row(ROW_CFG, 32'd2, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd1, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd2, 1'b0, 1'b1, 33'sd3);
    add_row(ROW_SAMPLE, 32'hffff_ffff, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd9, 1'b0, 1'b0, '0);
    // Rewriting the same size must still empty the window.
    add_row(ROW_CFG, 32'd2, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd9, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd3, 1'b0, 1'b1, 33'sd12);
    // Size zero acts as a window of one.
    add_row(ROW_CFG, 32'd0, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd7, 1'b0, 1'b1, 33'sd14);
    add_row(ROW_SAMPLE, 32'hffff_ffff, 1'b0, 1'b1, 33'sh1_ffff_fffe);
    // Oversized window saturates; a short stream gives nothing.
    add_row(ROW_CFG, 32'd127, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd1, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'd2, 1'b0, 1'b0, '0);
    add_row(ROW_CFG, 32'd1, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'haaaa_aaaa, 1'b0, 1'b0, '0);
    add_row(ROW_SAMPLE, 32'h5555_5555, 1'b0, 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_window_size(dir_rows[i].val[CFG_W-1:0]);
      end else begin
        offer_sample(dir_rows[i].val, dir_rows[i].sos, dir_rows[i].typed, dir_rows[i].med);
      end
    end

    // Back-pressure: the receiver holds off while samples keep coming.
    write_window_size(CFG_W'(3));
    hold_req = 1'b1;
    steady = 1'b1;
    for (k = 0; k < 40; k++) offer_sample($urandom, 1'b0, 1'b0, '0);
    steady = 1'b0;

    rand_items = 0;
    last_s = '0;
    while (rand_items < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60)      size = CFG_W'($urandom_range(1, 8));
      else if (r < 75) size = CFG_W'($urandom_range(9, 20));
      else if (r < 83) size = CFG_W'($urandom_range(21, 63));
      else if (r < 88) size = CFG_W'(MAXW);
      else if (r < 93) size = CFG_W'($urandom_range(65, 127));
      else if (r < 96) size = '0;
      else             size = CFG_W'($urandom_range(0, 127));
      write_window_size(size);
      n = win_span() + $urandom_range(4, 40);
      for (k = 0; k < n; k++) begin
        steady = (rand_items >= 150 && rand_items < 260);
        sos = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 59) == 0);
        r = $urandom_range(0, 99);
        if (r < 40)      s = $urandom;
        else if (r < 80) s = samp_t'(int'($urandom_range(0, 16)) - 8);
        else if (r < 90) begin
          case ($urandom_range(0, 3))
            0:       s = 32'sh7fff_ffff;
            1:       s = 32'sh8000_0000;
            2:       s = '0;
            default: s = -32'sd1;
          endcase
        end else begin
          s = last_s;
        end
        last_s = s;
        offer_sample(s, sos, 1'b0, '0);
        rand_items++;
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("sliding_window_median_top verification clean");
    end else begin
      $display("sliding_window_median_top verification failed");
    end
    $finish;
  end

endmodule
